FILE: hw/rtl/ple_pkg.sv
// Shared types and constants of the positional list engine.
package ple_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int VALUE_W          = 32;
    localparam int POS_W            = 8;

    typedef enum logic [2:0] {
        FN_INS_FIRST = 3'd0,
        FN_INS_LAST  = 3'd1,
        FN_INS_POS   = 3'd2,
        FN_DEL_FIRST = 3'd3,
        FN_DEL_LAST  = 3'd4,
        FN_DEL_POS   = 3'd5,
        FN_COUNT     = 3'd6,
        FN_LIST      = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

endpackage

FILE: hw/rtl/positional_list_engine.sv
// Top level of the positional list engine: an ordered list kept in a circular memory.
//
// A command transaction is taken at a rising edge where start is high and busy is low.
// Each result transaction is shown for exactly one cycle with done high; the receiver
// cannot hold results off, so the block never waits on it.
// The list lives in a single-port-write, single-port-read synchronous memory of
// CAPACITY words with a registered read, addressed from a head pointer.
// Inserting or deleting at the front or the back, a count, and any ignored or
// rejected command show their result in the cycle after start.
// A positional insert reads and writes back each element that it moves, one at a time,
// then writes the new value. A positional delete reads and writes back each moved
// element in turn and shows its result after the last write-back.
// Where nothing has to move, both finish like the commands above.
// A list command reads one element per cycle; each passes the memory read register and
// then the result registers, and they follow one per cycle, the final one with last set.
// A list of an empty list gives a single result with element_valid low.
// busy stays high until the final read of a list has reached the result registers.
// Reset clears the count and the head pointer; the memory is not cleared and needs
// no clearing pass, since only entries written earlier are ever read.
module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::DEFAULT_CAPACITY,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  ple_pkg::func_t                func,
    input  logic signed [ple_pkg::VALUE_W-1:0] value_in,
    input  logic [ple_pkg::POS_W-1:0]     position,
    output logic                          done,
    output logic signed [ple_pkg::VALUE_W-1:0] element_out,
    output logic                          element_valid,
    output logic                          last,
    output logic [CW-1:0]                 count_out,
    output ple_pkg::status_t              status
);
    import ple_pkg::*;

    localparam int IW  = $clog2(CAPACITY);
    localparam int PXW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SH_RD,
        S_SH_WR,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_LIST
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [IW-1:0]       head_reg, head_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic                rd_pend_reg, rd_last_reg;

    logic                done_reg;
    logic [VALUE_W-1:0]  element_out_reg;
    logic                element_valid_reg;
    logic                last_reg;
    logic [CW-1:0]       count_out_reg;
    status_t             status_reg;

    logic [VALUE_W-1:0]  mem [CAPACITY];
    logic [VALUE_W-1:0]  mem_rdata_reg;
    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    logic [VALUE_W-1:0]  mem_wdata;
    logic [IW-1:0]       mem_raddr;

    logic                res_fire;
    logic                res_empty_list;
    status_t             res_status;
    logic                rd_issue;
    logic                rd_last;

    logic [IW-1:0]       head_dec, head_inc;
    logic                full;
    logic [PXW-1:0]      pos_ext, cnt_ext;
    logic                ins_ok, del_ok;
    logic [CW-1:0]       ins_idx, del_idx;
    logic [CW:0]         i_plus2;

    // Physical slot of a logical position, counted from the head.
    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                              input logic [CW-1:0] logical);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(logical);
        if (sum >= (CW+1)'(CAPACITY)) begin
            sum = sum - (CW+1)'(CAPACITY);
        end
        return sum[IW-1:0];
    endfunction

    assign head_dec = (head_reg == '0) ? IW'(CAPACITY - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == IW'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;
    assign full     = (count_reg == CW'(CAPACITY));
    assign pos_ext  = PXW'(position);
    assign cnt_ext  = PXW'(count_reg);
    assign i_plus2  = (CW+1)'(i_reg) + (CW+1)'(2);

    always_comb
    begin
        ins_ok  = 1'b1;
        ins_idx = '0;
        case (func)
            FN_INS_FIRST: ins_idx = '0;
            FN_INS_LAST:  ins_idx = count_reg;
            FN_INS_POS:
            begin
                ins_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext + 1'b1);
                ins_idx = CW'(pos_ext - 1'b1);
            end
            default:      ins_idx = '0;
        endcase
    end

    always_comb
    begin
        del_ok  = (count_reg != '0);
        del_idx = '0;
        case (func)
            FN_DEL_FIRST: del_idx = '0;
            FN_DEL_LAST:  del_idx = count_reg - 1'b1;
            FN_DEL_POS:
            begin
                del_ok  = del_ok && (pos_ext != '0) && (pos_ext <= cnt_ext);
                del_idx = CW'(pos_ext - 1'b1);
            end
            default:      del_idx = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        i_next         = i_reg;
        idx_next       = idx_reg;
        value_next     = value_reg;
        mem_we         = 1'b0;
        mem_waddr      = slot_of(head_reg, i_reg);
        mem_wdata      = value_reg;
        mem_raddr      = slot_of(head_reg, i_reg);
        res_fire       = 1'b0;
        res_empty_list = 1'b0;
        res_status     = ST_DONE;
        rd_issue       = 1'b0;
        rd_last        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                // The final listed element is still on its way while busy is high.
                if (start && !busy)
                begin
                    value_next = value_in;
                    case (func)
                        FN_INS_FIRST, FN_INS_LAST, FN_INS_POS:
                        begin
                            if (full)
                            begin
                                res_fire   = 1'b1;
                                res_status = ST_FULL;
                            end
                            else if (!ins_ok)
                            begin
                                res_fire   = 1'b1;
                                res_status = ST_IGNORED;
                            end
                            else if (ins_idx == '0)
                            begin
                                head_next  = head_dec;
                                mem_we     = 1'b1;
                                mem_waddr  = head_dec;
                                mem_wdata  = value_in;
                                count_next = count_reg + 1'b1;
                                res_fire   = 1'b1;
                            end
                            else if (ins_idx == count_reg)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = slot_of(head_reg, count_reg);
                                mem_wdata  = value_in;
                                count_next = count_reg + 1'b1;
                                res_fire   = 1'b1;
                            end
                            else
                            begin
                                i_next     = count_reg;
                                idx_next   = ins_idx;
                                state_next = S_SH_RD;
                            end
                        end
                        FN_DEL_FIRST, FN_DEL_LAST, FN_DEL_POS:
                        begin
                            if (!del_ok)
                            begin
                                res_fire   = 1'b1;
                                res_status = ST_IGNORED;
                            end
                            else if (del_idx == '0)
                            begin
                                head_next  = head_inc;
                                count_next = count_reg - 1'b1;
                                res_fire   = 1'b1;
                            end
                            else if ((CW+1)'(del_idx) + 1'b1 < (CW+1)'(count_reg))
                            begin
                                i_next     = del_idx;
                                state_next = S_DEL_RD;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                res_fire   = 1'b1;
                            end
                        end
                        FN_COUNT:
                        begin
                            res_fire = 1'b1;
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                res_fire       = 1'b1;
                                res_empty_list = 1'b1;
                            end
                            else
                            begin
                                i_next     = '0;
                                state_next = S_LIST;
                            end
                        end
                    endcase
                end
            end
            S_SH_RD:
            begin
                mem_raddr  = slot_of(head_reg, i_reg - 1'b1);
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot_of(head_reg, i_reg);
                mem_wdata = mem_rdata_reg;
                i_next    = i_reg - 1'b1;
                if (i_reg - 1'b1 > idx_reg)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = slot_of(head_reg, idx_reg);
                mem_wdata  = value_reg;
                count_next = count_reg + 1'b1;
                res_fire   = 1'b1;
                state_next = S_IDLE;
            end
            S_DEL_RD:
            begin
                mem_raddr  = slot_of(head_reg, i_reg + 1'b1);
                state_next = S_DEL_WR;
            end
            S_DEL_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot_of(head_reg, i_reg);
                mem_wdata = mem_rdata_reg;
                i_next    = i_reg + 1'b1;
                if (i_plus2 < (CW+1)'(count_reg))
                begin
                    state_next = S_DEL_RD;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    res_fire   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                mem_raddr = slot_of(head_reg, i_reg);
                rd_issue  = 1'b1;
                rd_last   = (i_reg + 1'b1 == count_reg);
                i_next    = i_reg + 1'b1;
                if (rd_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            count_reg         <= '0;
            head_reg          <= '0;
            rd_pend_reg       <= 1'b0;
            rd_last_reg       <= 1'b0;
            done_reg          <= 1'b0;
            i_reg             <= '0;
            idx_reg           <= '0;
            value_reg         <= '0;
            element_out_reg   <= '0;
            element_valid_reg <= 1'b0;
            last_reg          <= 1'b0;
            count_out_reg     <= '0;
            status_reg        <= ST_DONE;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            i_reg       <= i_next;
            idx_reg     <= idx_next;
            value_reg   <= value_next;
            rd_pend_reg <= rd_issue;
            rd_last_reg <= rd_last;
            done_reg    <= res_fire || rd_pend_reg;
            // A listed element is taken from the memory read register in the cycle after its read is issued.
            if (rd_pend_reg)
            begin
                element_out_reg   <= mem_rdata_reg;
                element_valid_reg <= 1'b1;
                last_reg          <= rd_last_reg;
                count_out_reg     <= count_reg;
                status_reg        <= ST_DONE;
            end
            else if (res_fire)
            begin
                element_out_reg   <= '0;
                element_valid_reg <= 1'b0;
                last_reg          <= 1'b1;
                count_out_reg     <= count_next;
                status_reg        <= res_empty_list ? ST_DONE : res_status;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    assign busy          = (state_reg != S_IDLE) || rd_pend_reg;
    assign done          = done_reg;
    assign element_out   = element_out_reg;
    assign element_valid = element_valid_reg;
    assign last          = last_reg;
    assign count_out     = count_out_reg;
    assign status        = status_reg;

endmodule

FILE: tb/positional_list_engine_test.sv
// Self-checking testbench of the positional list engine: directed and random commands.
`timescale 1ns / 1ps

module positional_list_engine_test;

    import ple_pkg::*;

    localparam int CAP       = DEFAULT_CAPACITY;
    localparam int CNT_W     = $clog2(CAP + 1);
    localparam int LIMIT     = 200000;
    localparam int REPORT_N  = 10;
    localparam int PHASE_LEN = 110;

    typedef struct {
        logic signed [VALUE_W-1:0] element;
        logic                      valid;
        logic                      last_flag;
        logic [CNT_W-1:0]          count;
        status_t                   status;
    } list_result_t;

    // Tracks the list contents in logical order and the results they imply.
    class list_scoreboard;
        logic signed [VALUE_W-1:0] contents[$];
        list_result_t              awaited[$];
        int mismatches = 0;
        int commands   = 0;
        int results    = 0;
        int listed     = 0;
        int rejected   = 0;
        int ignored    = 0;

        function void add_result(logic signed [VALUE_W-1:0] elem, logic valid,
                                 logic lst, status_t st);
            list_result_t r;
            r.element   = elem;
            r.valid     = valid;
            r.last_flag = lst;
            r.count     = CNT_W'(contents.size());
            r.status    = st;
            awaited.push_back(r);
        endfunction

        function void note_command(func_t f, logic signed [VALUE_W-1:0] v,
                                   logic [POS_W-1:0] p);
            status_t st;
            int      n;
            int      pos;
            st  = ST_DONE;
            n   = contents.size();
            pos = int'(p);
            commands++;
            case (f)
                FN_INS_FIRST, FN_INS_LAST, FN_INS_POS:
                begin
                    // A full list rejects every insert before the position is looked at.
                    if (n >= CAP)
                        st = ST_FULL;
                    else if (f == FN_INS_FIRST)
                        contents.push_front(v);
                    else if (f == FN_INS_LAST)
                        contents.push_back(v);
                    else if (pos < 1 || pos > n + 1)
                        st = ST_IGNORED;
                    else
                        contents.insert(pos - 1, v);
                end
                FN_DEL_FIRST, FN_DEL_LAST, FN_DEL_POS:
                begin
                    if (n == 0)
                        st = ST_IGNORED;
                    else if (f == FN_DEL_FIRST)
                        void'(contents.pop_front());
                    else if (f == FN_DEL_LAST)
                        void'(contents.pop_back());
                    else if (pos < 1 || pos > n)
                        st = ST_IGNORED;
                    else
                        contents.delete(pos - 1);
                end
                FN_LIST:
                begin
                    if (n > 0)
                    begin
                        for (int i = 0; i < n; i++)
                            add_result(contents[i], 1'b1, (i == n - 1), ST_DONE);
                        listed += n;
                        return;
                    end
                end
                default:
                begin
                end
            endcase
            if (st == ST_FULL)
                rejected++;
            if (st == ST_IGNORED)
                ignored++;
            add_result('0, 1'b0, 1'b1, st);
        endfunction

        function void check_result(list_result_t got);
            list_result_t want;
            results++;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_N)
                    $display({"[%0t] unexpected result: elem=%0d valid=%0b last=%0b",
                              " count=%0d status=%0d"},
                             $realtime, got.element, got.valid, got.last_flag, got.count,
                             got.status);
                return;
            end
            want = awaited.pop_front();
            if (got.element !== want.element || got.valid !== want.valid ||
                got.last_flag !== want.last_flag || got.count !== want.count ||
                got.status !== want.status)
            begin
                mismatches++;
                if (mismatches <= REPORT_N)
                begin
                    $display({"[%0t] mismatch: expected elem=%0d valid=%0b last=%0b",
                              " count=%0d status=%0d"},
                             $realtime, want.element, want.valid, want.last_flag, want.count,
                             want.status);
                    $display({"             got      elem=%0d valid=%0b last=%0b",
                              " count=%0d status=%0d"},
                             got.element, got.valid, got.last_flag, got.count, got.status);
                end
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    func_t                     func;
    logic signed [VALUE_W-1:0] value_in;
    logic [POS_W-1:0]          position;
    logic                      done;
    logic signed [VALUE_W-1:0] element_out;
    logic                      element_valid;
    logic                      last;
    logic [CNT_W-1:0]          count_out;
    status_t                   status;

    list_scoreboard sb;
    list_result_t   seen;
    bit             growing    = 1'b1;
    int             burst_left = 0;

    func_t insert_kinds[3] = '{FN_INS_FIRST, FN_INS_LAST, FN_INS_POS};
    func_t delete_kinds[3] = '{FN_DEL_FIRST, FN_DEL_LAST, FN_DEL_POS};

    positional_list_engine DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .value_in      (value_in),
        .position      (position),
        .done          (done),
        .element_out   (element_out),
        .element_valid (element_valid),
        .last          (last),
        .count_out     (count_out),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen.element   = element_out;
            seen.valid     = element_valid;
            seen.last_flag = last;
            seen.count     = count_out;
            seen.status    = status;
            sb.check_result(seen);
        end
    end

    // Holds start with the command until a rising edge finds busy low.
    task automatic send_command(func_t f, logic signed [VALUE_W-1:0] v,
                                logic [POS_W-1:0] p, int idle_pct);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start    <= 1'b1;
        func     <= f;
        value_in <= v;
        position <= p;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_command(f, v, p);
    endtask

    // Bursts alternate between growing and shrinking the list so that it
    // regularly runs into both the full and the empty condition.
    task automatic send_random(int idle_pct);
        int                        n;
        int                        r;
        func_t                     f;
        logic signed [VALUE_W-1:0] v;
        logic [POS_W-1:0]          p;
        n = sb.contents.size();
        if (burst_left == 0)
        begin
            growing    = !growing;
            burst_left = $urandom_range(20, 40);
        end
        burst_left--;
        r = $urandom_range(0, 99);
        if (r < (growing ? 60 : 20))
            f = insert_kinds[$urandom_range(0, 2)];
        else if (r < 80)
            f = delete_kinds[$urandom_range(0, 2)];
        else if (r < 90)
            f = FN_COUNT;
        else
            f = FN_LIST;
        case ($urandom_range(0, 9))
            0:       v = 32'sh7fffffff;
            1:       v = 32'sh80000000;
            2:       v = '0;
            default: v = $urandom;
        endcase
        if ($urandom_range(0, 7) == 0)
            p = POS_W'($urandom_range(0, 255));
        else
            p = POS_W'($urandom_range(0, n + 2));
        send_command(f, v, p, idle_pct);
    endtask

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles with %0d results outstanding.", LIMIT,
                 sb.awaited.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        sb       = new();
        rst_n    = 1'b0;
        start    = 1'b0;
        func     = FN_COUNT;
        value_in = '0;
        position = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Empty-list corner cases.
        send_command(FN_LIST,      0, 0, 0);
        send_command(FN_COUNT,     0, 0, 0);
        send_command(FN_DEL_FIRST, 0, 0, 0);
        send_command(FN_DEL_LAST,  0, 0, 0);
        send_command(FN_DEL_POS,   0, 1, 0);
        send_command(FN_INS_POS,   5, 0, 0);
        send_command(FN_INS_POS,   5, 2, 0);
        // Building a short list with extreme values, then positions out of range and at the end.
        send_command(FN_INS_POS,   32'sh7fffffff, 1, 0);
        send_command(FN_INS_FIRST, 32'sh80000000, 0, 0);
        send_command(FN_INS_LAST,  -1, 8'hff, 0);
        send_command(FN_INS_POS,   7, 8'hff, 0);
        send_command(FN_INS_POS,   0, 4, 0);
        send_command(FN_DEL_POS,   0, 0, 0);
        send_command(FN_DEL_POS,   0, 5, 0);
        send_command(FN_LIST,      0, 0, 0);
        send_command(FN_DEL_POS,   0, 2, 0);
        send_command(FN_DEL_LAST,  0, 0, 0);
        send_command(FN_LIST,      0, 0, 0);
        send_command(FN_DEL_FIRST, 0, 0, 0);
        send_command(FN_COUNT,     0, 0, 0);

        for (int ph = 0; ph < 3; ph++)
            repeat (PHASE_LEN) send_random(ph == 0 ? 20 : (ph == 1 ? 75 : 0));
        start <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (2 * CAP + 8) @(posedge clk);

        $display("Ran %0d commands, checked %0d results including %0d listed elements.",
                 sb.commands, sb.results, sb.listed);
        $display("Inserts rejected on a full list: %0d; commands ignored: %0d.",
                 sb.rejected, sb.ignored);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived.", sb.mismatches,
                     sb.awaited.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/ple_pkg.sv
hw/rtl/positional_list_engine.sv
tb/positional_list_engine_test.sv
